// ----- sv/modem_wake_handshake_controller_unit_macros.svh -----
// Assertion macros for the modem wake handshake controller.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MODEM_WAKE_HANDSHAKE_CONTROLLER_UNIT_MACROS_SVH
`define MODEM_WAKE_HANDSHAKE_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define MWHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwhc check failed");

// next-cycle implication
`define MWHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwhc check failed");

`endif

// ----- sv/mwhc_pkg.sv -----
// Shared types and constants for the modem wake handshake controller.
// No dependencies.
`default_nettype none

package mwhc_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] INACT_RST = 16'd100;
  localparam logic [CFG_W-1:0] RETRY_RST = 16'd1000;
  localparam logic [3:0] WARN_FULL = 4'd10;

  localparam logic CFG_INACT = 1'b0;
  localparam logic CFG_RETRY = 1'b1;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_WAKE    = 3'd1;
  localparam logic [2:0] REQ_EDGE    = 3'd2;
  localparam logic [2:0] REQ_SUSPEND = 3'd3;
  localparam logic [2:0] REQ_RESUME  = 3'd4;
  localparam logic [2:0] REQ_ENABLE  = 3'd5;
  localparam logic [2:0] REQ_DISABLE = 3'd6;
  localparam logic [2:0] REQ_STOP    = 3'd7;

  typedef enum logic [2:0] {
    MODE_ASLEEP      = 3'd0,
    MODE_WKUP_WAIT   = 3'd1,
    MODE_AWAKE_WAIT  = 3'd2,
    MODE_AWAKE       = 3'd3,
    MODE_SLEEP_WAIT  = 3'd4,
    MODE_ASLEEP_WAIT = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       port_busy;
  } mwhc_in_t;

  typedef struct packed {
    logic       wake_line;
    logic [2:0] mode;
    logic       is_awake;
    logic       note_prewake;
    logic       note_awake;
    logic       note_sleep;
    logic       note_asleep;
    logic       timeout_warning;
  } mwhc_out_t;

endpackage

`default_nettype wire

// ----- sv/mwhc_in_stage.sv -----
// Input register of the modem wake handshake controller.
// Depends on mwhc_pkg.
`default_nettype none

module mwhc_in_stage
  import mwhc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire mwhc_in_t in_data,
  input  wire logic     advance,
  output logic          item_valid,
  output mwhc_in_t      item
);

  logic     valid_r, valid_nxt;
  mwhc_in_t data_r, data_nxt;
  logic     take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (take) begin
      valid_nxt = 1'b1;
      data_nxt  = in_data;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign item_valid = valid_r;
  assign item       = data_r;

endmodule

`default_nettype wire

// ----- sv/mwhc_step.sv -----
// Handshake state and the combinational event logic.
// Depends on mwhc_pkg.
`default_nettype none

module mwhc_step
  import mwhc_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire mwhc_in_t         item,
  input  wire logic [CFG_W-1:0] inact_ticks,
  input  wire logic [CFG_W-1:0] retry_ticks,
  output mwhc_out_t             result
);

  typedef struct packed {
    mode_t                 phase;
    logic                  pend;
    logic                  ack;
    logic                  hs_on;
    logic                  susp;
    logic [TIMER_BITS-1:0] idle_cnt;
    logic                  idle_run;
    logic [TIMER_BITS-1:0] retry_cnt;
    logic                  retry_run;
    logic [3:0]            warn;
    logic                  line;
  } state_t;

  typedef struct packed {
    state_t st;
    logic   p_prewake;
    logic   p_awake;
    logic   p_sleep;
    logic   p_asleep;
    logic   p_warn;
  } work_t;

  state_t state_r, state_nxt;
  work_t  w;

  function automatic work_t go_awake(work_t a, logic [CFG_W-1:0] inact);
    a.st.retry_run = 1'b0;
    a.st.warn      = WARN_FULL;
    a.p_prewake    = 1'b1;
    a.st.phase     = MODE_AWAKE;
    a.st.pend      = 1'b0;
    if (a.st.hs_on && a.st.susp) begin
      a.st.idle_cnt = TIMER_BITS'(inact);
      a.st.idle_run = 1'b1;
    end
    a.p_awake = 1'b1;
    return a;
  endfunction

  function automatic work_t settle(work_t a, logic [CFG_W-1:0] inact,
                                   logic [CFG_W-1:0] rtk);
    logic done;
    done = 1'b0;
    for (int pass = 0; pass < 3; pass++) begin
      if (!done && a.st.phase == MODE_ASLEEP) begin
        if (!a.st.pend) begin
          done = 1'b1;
        end else begin
          a.st.phase = MODE_WKUP_WAIT;
        end
      end
      if (!done && a.st.phase == MODE_WKUP_WAIT) begin
        a.st.phase     = MODE_AWAKE_WAIT;
        a.st.ack       = 1'b0;
        a.st.line      = 1'b1;
        a.st.retry_cnt = TIMER_BITS'(rtk);
        a.st.retry_run = 1'b1;
        if (!a.st.hs_on) begin
          a    = go_awake(a, inact);
          done = 1'b1;
        end
      end
      if (!done && a.st.phase == MODE_AWAKE_WAIT) begin
        if (a.st.ack) begin
          a = go_awake(a, inact);
        end
        done = 1'b1;
      end
      if (!done && a.st.phase == MODE_SLEEP_WAIT) begin
        a.st.phase = MODE_ASLEEP_WAIT;
        a.p_sleep  = 1'b1;
        a.st.line  = 1'b0;
      end
      if (!done) begin
        if (a.st.phase == MODE_ASLEEP_WAIT) begin
          a.st.phase = MODE_ASLEEP;
          a.p_asleep = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
    end
    return a;
  endfunction

  function automatic work_t wake_req(work_t a, logic [CFG_W-1:0] inact);
    a.st.idle_run = 1'b0;
    if (a.st.phase == MODE_AWAKE) begin
      if (a.st.hs_on && a.st.susp) begin
        a.st.idle_cnt = TIMER_BITS'(inact);
        a.st.idle_run = 1'b1;
      end
    end else begin
      a.st.pend = 1'b1;
    end
    return a;
  endfunction

  function automatic work_t do_tick(work_t a, logic busy, logic [CFG_W-1:0] inact,
                                    logic [CFG_W-1:0] rtk);
    if (a.st.idle_run) begin
      if (a.st.idle_cnt <= TIMER_BITS'(1)) begin
        if (busy) begin
          a.st.idle_cnt = TIMER_BITS'(inact);
        end else begin
          a.st.idle_run = 1'b0;
          a.st.phase    = MODE_SLEEP_WAIT;
          a             = settle(a, inact, rtk);
        end
      end else begin
        a.st.idle_cnt = a.st.idle_cnt - TIMER_BITS'(1);
      end
    end
    if (a.st.retry_run) begin
      if (a.st.retry_cnt <= TIMER_BITS'(1)) begin
        a.st.retry_run = 1'b0;
        if (a.st.warn != 4'd0) begin
          a.st.warn = a.st.warn - 4'd1;
          a.p_warn  = 1'b1;
        end
        a.st.line  = 1'b0;
        a.st.phase = MODE_WKUP_WAIT;
        a.st.pend  = 1'b1;
        a          = settle(a, inact, rtk);
      end else begin
        a.st.retry_cnt = a.st.retry_cnt - TIMER_BITS'(1);
      end
    end
    return a;
  endfunction

  function automatic work_t do_stop(work_t a);
    a.st.idle_run = 1'b0;
    a.st.line     = 1'b0;
    a.st.phase    = MODE_ASLEEP;
    a.st.pend     = 1'b0;
    return a;
  endfunction

  always_comb begin
    w           = '0;
    w.st        = state_r;
    case (item.req_type)
      REQ_TICK: begin
        w = do_tick(w, item.port_busy, inact_ticks, retry_ticks);
      end
      REQ_WAKE: begin
        w = wake_req(w, inact_ticks);
      end
      REQ_EDGE: begin
        w.st.retry_run = 1'b0;
        if (w.st.hs_on) begin
          if (w.st.phase == MODE_AWAKE_WAIT) begin
            w.st.ack = 1'b1;
          end else if (w.st.phase == MODE_ASLEEP || w.st.phase == MODE_SLEEP_WAIT ||
                       w.st.phase == MODE_ASLEEP_WAIT) begin
            w.st.pend = 1'b1;
          end
        end
      end
      REQ_SUSPEND: begin
        w.st.susp = 1'b1;
        if (w.st.phase == MODE_AWAKE && w.st.hs_on) begin
          w.st.idle_cnt = TIMER_BITS'(1);
          w.st.idle_run = 1'b1;
        end
      end
      REQ_RESUME: begin
        w.st.susp = 1'b0;
        if (w.st.phase == MODE_AWAKE) begin
          w.st.idle_run = 1'b0;
        end
        w = wake_req(w, inact_ticks);
      end
      REQ_ENABLE: begin
        if (!w.st.hs_on) begin
          w.st.hs_on = 1'b1;
          if (w.st.phase == MODE_AWAKE && w.st.susp) begin
            w.st.idle_cnt = TIMER_BITS'(inact_ticks);
            w.st.idle_run = 1'b1;
          end
        end
      end
      REQ_DISABLE: begin
        if (w.st.hs_on) begin
          w.st.hs_on = 1'b0;
          if (w.st.phase == MODE_AWAKE) begin
            w.st.idle_run = 1'b0;
          end else if (w.st.phase == MODE_AWAKE_WAIT) begin
            w.st.ack = 1'b1;
          end else begin
            w.st.pend = 1'b1;
          end
        end
      end
      REQ_STOP: begin
        w = do_stop(w);
      end
      default: begin
        w = do_stop(w);
      end
    endcase
    w = settle(w, inact_ticks, retry_ticks);
  end

  always_comb begin
    state_nxt = state_r;
    if (step_en) begin
      state_nxt = w.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= MODE_ASLEEP;
      state_r.pend      <= 1'b0;
      state_r.ack       <= 1'b0;
      state_r.hs_on     <= 1'b1;
      state_r.susp      <= 1'b0;
      state_r.idle_cnt  <= '0;
      state_r.idle_run  <= 1'b0;
      state_r.retry_cnt <= '0;
      state_r.retry_run <= 1'b0;
      state_r.warn      <= WARN_FULL;
      state_r.line      <= 1'b0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign result.wake_line       = w.st.line;
  assign result.mode            = w.st.phase;
  assign result.is_awake        = (w.st.phase == MODE_AWAKE);
  assign result.note_prewake    = w.p_prewake;
  assign result.note_awake      = w.p_awake;
  assign result.note_sleep      = w.p_sleep;
  assign result.note_asleep     = w.p_asleep;
  assign result.timeout_warning = w.p_warn;

endmodule

`default_nettype wire

// ----- sv/mwhc_out_stage.sv -----
// Result register of the modem wake handshake controller.
// Depends on mwhc_pkg.
`default_nettype none

module mwhc_out_stage
  import mwhc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire mwhc_out_t result,
  output logic           out_free,
  output logic           out_valid,
  input  wire logic      out_stall,
  output mwhc_out_t      out_data
);

  logic      valid_r, valid_nxt;
  mwhc_out_t data_r, data_nxt;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ----- sv/modem_wake_handshake_controller_unit.sv -----
// An accepted item waits in the input register; its result is then loaded
// into the result register and shown on out_data.
// Throughput: one item per cycle while out_stall does not hold the result;
// the event logic between the two registers settles each event combinationally.
// Reset: synchronous, active low; mode asleep, handshake on, timers stopped,
// inactivity_ticks 100, retry_ticks 1000. Ready straight after reset.
`default_nettype none

`include "modem_wake_handshake_controller_unit_macros.svh"

module modem_wake_handshake_controller_unit
  import mwhc_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mwhc_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mwhc_out_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic             item_valid;
  mwhc_in_t         item;
  logic             out_free;
  logic             advance;
  mwhc_out_t        result;
  logic [CFG_W-1:0] inact_r, inact_nxt;
  logic [CFG_W-1:0] retry_r, retry_nxt;

  assign cfg_ready = 1'b1;
  assign advance   = item_valid && out_free;

  always_comb begin
    inact_nxt = inact_r;
    retry_nxt = retry_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INACT: inact_nxt = cfg_data;
        CFG_RETRY: retry_nxt = cfg_data;
        default: begin
          inact_nxt = inact_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inact_r <= INACT_RST;
      retry_r <= RETRY_RST;
    end else begin
      inact_r <= inact_nxt;
      retry_r <= retry_nxt;
    end
  end

  mwhc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mwhc_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item        (item),
    .inact_ticks (inact_r),
    .retry_ticks (retry_r),
    .result      (result)
  );

  mwhc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `MWHC_ASSERT_NEXT(a_item_held, item_valid && !advance, item_valid)
  `MWHC_ASSERT_NOW(a_mode_settled, out_valid,
    out_data.mode == MODE_ASLEEP || out_data.mode == MODE_AWAKE_WAIT ||
    out_data.mode == MODE_AWAKE)
  `MWHC_ASSERT_NOW(a_awake_note, out_valid && out_data.note_awake,
    out_data.is_awake && out_data.note_prewake)

endmodule

`default_nettype wire

// ----- tb/mwhc_checker.sv -----
`timescale 1ns / 100ps
// Checker for the modem wake handshake controller: watches the event, status and
// register write channels, predicts every status transfer and compares it by field.
// Depends on mwhc_pkg only.

module mwhc_checker
  import mwhc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  mwhc_in_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  mwhc_out_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatches,
  output int               outstanding
);

  localparam int TW = TIMER_BITS_DEF;

  logic [CFG_W-1:0] inact_ld, retry_ld;
  mode_t            ph;
  logic             pend, acked, hs_on, suspended, idle_run, retry_run, line;
  logic [TW-1:0]    idle_cnt, retry_cnt;
  logic [3:0]       budget;
  logic             f_prewake, f_awake, f_sleep, f_asleep, f_warn;
  mwhc_out_t        expected_status_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input int expv, input int gotv);
    if (mismatches < 100)
      $display("ERROR %0t: %0s expected %0d got %0d", $realtime, what, expv, gotv);
    mismatches++;
  endtask

  function automatic void reset_model();
    inact_ld  = INACT_RST;
    retry_ld  = RETRY_RST;
    ph        = MODE_ASLEEP;
    pend      = 1'b0;
    acked     = 1'b0;
    hs_on     = 1'b1;
    suspended = 1'b0;
    idle_cnt  = '0;
    idle_run  = 1'b0;
    retry_cnt = '0;
    retry_run = 1'b0;
    budget    = WARN_FULL;
    line      = 1'b0;
  endfunction

  function automatic void start_idle(input logic [CFG_W-1:0] n);
    idle_cnt = TW'(n);
    idle_run = 1'b1;
  endfunction

  function automatic void enter_awake();
    retry_run = 1'b0;
    budget    = WARN_FULL;
    f_prewake = 1'b1;
    ph        = MODE_AWAKE;
    pend      = 1'b0;
    if (hs_on && suspended)
      start_idle(inact_ld);
    f_awake = 1'b1;
  endfunction

  // collapse the transient modes within one event
  function automatic void run_transients();
    for (int pass = 0; pass < 3; pass++) begin
      if (ph == MODE_ASLEEP) begin
        if (!pend)
          return;
        ph = MODE_WKUP_WAIT;
      end
      if (ph == MODE_WKUP_WAIT) begin
        ph        = MODE_AWAKE_WAIT;
        acked     = 1'b0;
        line      = 1'b1;
        retry_cnt = TW'(retry_ld);
        retry_run = 1'b1;
        if (!hs_on) begin
          enter_awake();
          return;
        end
      end
      if (ph == MODE_AWAKE_WAIT) begin
        if (acked)
          enter_awake();
        return;
      end
      if (ph == MODE_SLEEP_WAIT) begin
        ph      = MODE_ASLEEP_WAIT;
        f_sleep = 1'b1;
        line    = 1'b0;
      end
      if (ph == MODE_ASLEEP_WAIT) begin
        ph       = MODE_ASLEEP;
        f_asleep = 1'b1;
        continue;
      end
      return;
    end
  endfunction

  function automatic void take_wake_request();
    idle_run = 1'b0;
    if (ph == MODE_AWAKE) begin
      if (hs_on && suspended)
        start_idle(inact_ld);
      return;
    end
    pend = 1'b1;
  endfunction

  function automatic void take_tick(input logic busy);
    if (idle_run) begin
      if (idle_cnt <= 1) begin
        if (busy) begin
          start_idle(inact_ld);
        end else begin
          idle_run = 1'b0;
          ph       = MODE_SLEEP_WAIT;
          run_transients();
        end
      end else begin
        idle_cnt--;
      end
    end
    if (retry_run) begin
      if (retry_cnt <= 1) begin
        retry_run = 1'b0;
        if (budget != 0) begin
          budget--;
          f_warn = 1'b1;
        end
        line = 1'b0;
        ph   = MODE_WKUP_WAIT;
        pend = 1'b1;
        run_transients();
      end else begin
        retry_cnt--;
      end
    end
  endfunction

  function automatic mwhc_out_t predict_status(input mwhc_in_t ev);
    mwhc_out_t r;
    f_prewake = 1'b0;
    f_awake   = 1'b0;
    f_sleep   = 1'b0;
    f_asleep  = 1'b0;
    f_warn    = 1'b0;
    case (ev.req_type)
      REQ_TICK: take_tick(ev.port_busy);
      REQ_WAKE: take_wake_request();
      REQ_EDGE: begin
        retry_run = 1'b0;
        if (hs_on) begin
          if (ph == MODE_AWAKE_WAIT)
            acked = 1'b1;
          else if (ph == MODE_ASLEEP || ph == MODE_SLEEP_WAIT || ph == MODE_ASLEEP_WAIT)
            pend = 1'b1;
        end
      end
      REQ_SUSPEND: begin
        suspended = 1'b1;
        if (ph == MODE_AWAKE && hs_on)
          start_idle(1);
      end
      REQ_RESUME: begin
        suspended = 1'b0;
        if (ph == MODE_AWAKE)
          idle_run = 1'b0;
        take_wake_request();
      end
      REQ_ENABLE: begin
        if (!hs_on) begin
          hs_on = 1'b1;
          if (ph == MODE_AWAKE && suspended)
            start_idle(inact_ld);
        end
      end
      REQ_DISABLE: begin
        if (hs_on) begin
          hs_on = 1'b0;
          if (ph == MODE_AWAKE)
            idle_run = 1'b0;
          else if (ph == MODE_AWAKE_WAIT)
            acked = 1'b1;
          else
            pend = 1'b1;
        end
      end
      default: begin
        idle_run = 1'b0;
        line     = 1'b0;
        ph       = MODE_ASLEEP;
        pend     = 1'b0;
      end
    endcase
    run_transients();
    r.wake_line       = line;
    r.mode            = ph;
    r.is_awake        = (ph == MODE_AWAKE);
    r.note_prewake    = f_prewake;
    r.note_awake      = f_awake;
    r.note_sleep      = f_sleep;
    r.note_asleep     = f_asleep;
    r.timeout_warning = f_warn;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    mwhc_out_t want;
    if (!rst_n) begin
      reset_model();
      expected_status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch("status transfer with none expected", 0, int'(out_data));
        end else begin
          want = expected_status_q.pop_front();
          if (out_data.wake_line !== want.wake_line)
            report_mismatch("wake_line", want.wake_line, out_data.wake_line);
          if (out_data.mode !== want.mode)
            report_mismatch("mode", want.mode, out_data.mode);
          if (out_data.is_awake !== want.is_awake)
            report_mismatch("is_awake", want.is_awake, out_data.is_awake);
          if (out_data.note_prewake !== want.note_prewake)
            report_mismatch("note_prewake", want.note_prewake, out_data.note_prewake);
          if (out_data.note_awake !== want.note_awake)
            report_mismatch("note_awake", want.note_awake, out_data.note_awake);
          if (out_data.note_sleep !== want.note_sleep)
            report_mismatch("note_sleep", want.note_sleep, out_data.note_sleep);
          if (out_data.note_asleep !== want.note_asleep)
            report_mismatch("note_asleep", want.note_asleep, out_data.note_asleep);
          if (out_data.timeout_warning !== want.timeout_warning)
            report_mismatch("timeout_warning", want.timeout_warning,
                            out_data.timeout_warning);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_INACT)
          inact_ld = cfg_data;
        else
          retry_ld = cfg_data;
      end
      if (in_valid && !in_stall)
        expected_status_q.push_back(predict_status(in_data));
    end
    outstanding = expected_status_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the modem wake handshake controller testbench: clock, reset, event and
// register stimulus, receiver back-pressure, watchdog and verdict.
// Depends on mwhc_pkg, modem_wake_handshake_controller_unit and mwhc_checker.

module testbench;
  import mwhc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int SQUEEZE_LEN = 80;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  mwhc_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  mwhc_out_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int               mismatches;
  int               outstanding;
  int               sent;
  int               quiet_cycles = 0;
  int               run_left;
  bit               idle_on;
  bit               stall_en;
  bit               squeeze;
  logic [CFG_W-1:0] cur_inact;
  logic [CFG_W-1:0] cur_retry;
  logic [CFG_W-1:0] inact_set [0:PHASES-1];
  logic [CFG_W-1:0] retry_set [0:PHASES-1];

  modem_wake_handshake_controller_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mwhc_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [2:0] pick_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return REQ_TICK;
    if (r < 57) return REQ_WAKE;
    if (r < 69) return REQ_EDGE;
    if (r < 77) return REQ_SUSPEND;
    if (r < 84) return REQ_RESUME;
    if (r < 90) return REQ_ENABLE;
    if (r < 95) return REQ_DISABLE;
    return REQ_STOP;
  endfunction

  function automatic logic pick_busy();
    return ($urandom_range(0, 4) == 0);
  endfunction

  task automatic send_event(input logic [2:0] req, input logic busy);
    int       g;
    mwhc_in_t ev;
    g = idle_on ? pick_gap() : 0;
    ev.req_type  = req;
    ev.port_busy = busy;
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every expected transfer is back, then let the pipeline empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_session();
    int r;
    int k;
    int lim;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      send_event(REQ_WAKE, pick_busy());
      lim = (cur_retry > 8) ? 8 : int'(cur_retry);
      k   = $urandom_range(0, lim + 1);
      repeat (k) send_event(REQ_TICK, pick_busy());
      if ($urandom_range(0, 3) != 0)
        send_event(REQ_EDGE, pick_busy());
      send_event(REQ_SUSPEND, pick_busy());
      lim = (cur_inact > 20) ? 20 : int'(cur_inact);
      k   = $urandom_range(0, lim + 2);
      repeat (k) send_event(REQ_TICK, pick_busy());
      if ($urandom_range(0, 4) == 0)
        send_event(REQ_RESUME, pick_busy());
    end else if (r < 7) begin
      // try to run the warning budget dry (enough ticks only for retry_ticks of four or less)
      send_event(REQ_WAKE, pick_busy());
      lim = (cur_retry > 4) ? 4 : int'(cur_retry);
      repeat (12 * lim + 2) send_event(REQ_TICK, pick_busy());
    end else begin
      k = $urandom_range(1, 6);
      repeat (k) send_event(pick_req(), $urandom_range(0, 1));
    end
  endtask

  initial begin
    out_stall = 1'b0;
    run_left  = 0;
    forever begin
      @(negedge clk);
      if (squeeze) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_LEN) @(negedge clk);
        squeeze = 1'b0;
        out_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        out_stall <= stall_en && ($urandom_range(0, 2) == 0);
        run_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_INACT;
    cfg_data  = '0;
    idle_on   = 1'b1;
    stall_en  = 1'b1;
    squeeze   = 1'b0;
    sent      = 0;
    inact_set = '{16'd1, 16'd2, 16'd65535, 16'd5, 16'd1, 16'd65535, 16'd3, 16'd100};
    retry_set = '{16'd1, 16'd3, 16'd65535, 16'd12, 16'd65535, 16'd1, 16'd2, 16'd1000};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cur_inact = 16'd2;
    cur_retry = 16'd3;
    write_reg(CFG_INACT, cur_inact);
    write_reg(CFG_RETRY, cur_retry);

    send_event(REQ_TICK, 1'b0);
    send_event(REQ_WAKE, 1'b0);
    send_event(REQ_TICK, 1'b1);
    send_event(REQ_TICK, 1'b0);
    send_event(REQ_TICK, 1'b0);
    send_event(REQ_EDGE, 1'b0);
    send_event(REQ_WAKE, 1'b1);
    send_event(REQ_SUSPEND, 1'b0);
    send_event(REQ_TICK, 1'b1);
    send_event(REQ_WAKE, 1'b0);
    send_event(REQ_TICK, 1'b0);
    send_event(REQ_TICK, 1'b0);
    send_event(REQ_EDGE, 1'b1);
    send_event(REQ_DISABLE, 1'b0);
    send_event(REQ_EDGE, 1'b0);
    send_event(REQ_ENABLE, 1'b1);
    send_event(REQ_ENABLE, 1'b0);
    send_event(REQ_RESUME, 1'b1);
    send_event(REQ_DISABLE, 1'b0);
    send_event(REQ_DISABLE, 1'b1);
    send_event(REQ_STOP, 1'b0);
    send_event(REQ_WAKE, 1'b0);
    send_event(REQ_ENABLE, 1'b0);
    send_event(REQ_STOP, 1'b1);
    send_event(REQ_TICK, 1'b1);

    for (int p = 0; p < PHASES; p++) begin : phase_loop
      int target;
      drain();
      cur_inact = inact_set[p];
      cur_retry = retry_set[p];
      write_reg(CFG_INACT, cur_inact);
      write_reg(CFG_RETRY, cur_retry);
      idle_on  = (p == 0) ? 1'b0 : ($urandom_range(0, 4) != 0);
      stall_en = (p == 0) ? 1'b0 : ($urandom_range(0, 4) != 0);
      if (p == 2 || p == 5)
        squeeze = 1'b1;
      target = sent + PHASE_ITEMS;
      while (sent < target) run_session();
    end

    drain();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mwhc_pkg.sv
sv/mwhc_in_stage.sv
sv/mwhc_step.sv
sv/mwhc_out_stage.sv
sv/modem_wake_handshake_controller_unit.sv
tb/mwhc_checker.sv
tb/testbench.sv
